### rtl/core/bcgb_pkg.sv
// Package for the buffer cache controller: widths, status codes, actions and flag bits.
// No dependencies.
`default_nettype none
package bcgb_pkg;
    localparam int NumBuffersDef = 16;
    localparam int BlockBitsDef  = 16;
    localparam int ActW    = 2;
    localparam int BlkInW  = 16;
    localparam int SelW    = 3;
    localparam int StatW   = 4;
    localparam int IdxOutW = 4;
    localparam int FlagW   = 5;

    localparam logic [ActW-1:0] ACT_GET = 2'd0;
    localparam logic [ActW-1:0] ACT_REL = 2'd1;
    localparam logic [ActW-1:0] ACT_SET = 2'd2;
    localparam logic [ActW-1:0] ACT_CLR = 2'd3;

    localparam logic [StatW-1:0] ST_HIT       = 4'd0;
    localparam logic [StatW-1:0] ST_REPLACED  = 4'd1;
    localparam logic [StatW-1:0] ST_WRITEBACK = 4'd2;
    localparam logic [StatW-1:0] ST_EMPTY     = 4'd3;
    localparam logic [StatW-1:0] ST_LOCKWAIT  = 4'd4;
    localparam logic [StatW-1:0] ST_RELEASED  = 4'd5;
    localparam logic [StatW-1:0] ST_NOTCACHED = 4'd6;
    localparam logic [StatW-1:0] ST_NOTLOCKED = 4'd7;
    localparam logic [StatW-1:0] ST_INVALID   = 4'd8;
    localparam logic [StatW-1:0] ST_FLAGDONE  = 4'd9;
    localparam logic [StatW-1:0] ST_FLAGMISS  = 4'd10;

    localparam int F_LOCKED = 0;
    localparam int F_VALID  = 1;
    localparam int F_DWR    = 2;
    localparam int F_OLD    = 3;
    localparam int F_WAITED = 4;
    localparam logic [SelW-1:0] SEL_MAX = 3'd4;

    typedef struct packed {
        logic [StatW-1:0]   status;
        logic [IdxOutW-1:0] buffer_index;
        logic [BlkInW-1:0]  other_block;
        logic               other_block_present;
        logic               wake_any;
        logic               wake_block_waiters;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [ActW-1:0]   action;
        logic [BlkInW-1:0] block_number;
        logic [SelW-1:0]   flag_select;
    } t_request;
endpackage
`default_nettype wire

### rtl/core/bcgb_if.sv
// Valid/ready channel interface carrying a request or result item.
// Depends on bcgb_pkg.
`default_nettype none
interface bcgb_req_if import bcgb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_request payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bcgb_res_if import bcgb_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/core/bcgb_lookup.sv
// Parallel tag match over hashed buffers, lowest index wins, registered result.
// Depends on bcgb_pkg.
`default_nettype none
module bcgb_lookup import bcgb_pkg::*; #(
    parameter int NUM_BUFFERS = NumBuffersDef,
    parameter int BLOCK_BITS  = BlockBitsDef,
    localparam int IW = $clog2(NUM_BUFFERS)
) (
    input  wire logic                   i_clk,
    input  wire logic [NUM_BUFFERS-1:0][BLOCK_BITS-1:0] i_tags,
    input  wire logic [NUM_BUFFERS-1:0] i_hashed,
    input  wire logic [BLOCK_BITS-1:0]  i_blk,
    output logic                        o_hit,
    output logic [IW-1:0]               o_idx
);
    logic          n_hit;
    logic [IW-1:0] n_idx;
    logic          r_hit;
    logic [IW-1:0] r_idx;

    always_comb begin
        n_hit = 1'b0;
        n_idx = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            if (i_hashed[i] && i_tags[i] == i_blk) begin
                n_hit = 1'b1;
                n_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
        r_idx <= n_idx;
    end

    assign o_hit = r_hit;
    assign o_idx = r_idx;
endmodule
`default_nettype wire

### rtl/core/buffer_cache_getblk_brelse.sv
// Buffer cache controller top level: sequencer, buffer state and free list.
// A request passes through the lookup, work and output states; a get that walks dirty
// buffers gives one writeback item per dirty buffer, each costing a work and an output state.
// One request at a time: a new request is taken only when idle, after the final result.
// Reset: synchronous active low; all buffers free in index order, untagged.
// Depends on bcgb_pkg, bcgb_if and bcgb_lookup.
`default_nettype none
module buffer_cache_getblk_brelse import bcgb_pkg::*; #(
    parameter int NUM_BUFFERS = NumBuffersDef,
    parameter int BLOCK_BITS  = BlockBitsDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bcgb_req_if.sink   req,
    bcgb_res_if.source res
);
    localparam int IW = $clog2(NUM_BUFFERS);
    localparam int CW = $clog2(NUM_BUFFERS + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(NUM_BUFFERS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_WORK = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [NUM_BUFFERS-1:0][BLOCK_BITS-1:0] r_tag;
    logic [NUM_BUFFERS-1:0] r_hash;
    logic [NUM_BUFFERS-1:0][FlagW-1:0] r_flags;
    logic [NUM_BUFFERS-1:0] r_onfl;
    logic [NUM_BUFFERS-1:0][IW-1:0] r_next, r_prev;
    logic [IW-1:0] r_head, r_tail;
    logic [CW-1:0] r_cnt;
    t_request r_req;
    t_result  r_res;
    logic     r_done;

    logic [BLOCK_BITS-1:0] w_blk;
    logic          w_hit;
    logic [IW-1:0] w_hidx;

    assign w_blk = r_req.block_number[BLOCK_BITS-1:0];

    bcgb_lookup #(.NUM_BUFFERS(NUM_BUFFERS), .BLOCK_BITS(BLOCK_BITS)) u_lookup (
        .i_clk(i_clk), .i_tags(r_tag), .i_hashed(r_hash), .i_blk(w_blk),
        .o_hit(w_hit), .o_idx(w_hidx)
    );

    assign req.ready   = (r_state == S_IDLE);
    assign res.valid   = (r_state == S_OUT);
    assign res.payload = r_res;

    function automatic logic [BlkInW-1:0] ext_blk(input logic [BLOCK_BITS-1:0] b);
        logic [BlkInW+BLOCK_BITS-1:0] t;
        t = {{BlkInW{1'b0}}, b};
        return t[BlkInW-1:0];
    endfunction

    function automatic logic [IdxOutW-1:0] ext_idx(input logic [IW-1:0] b);
        logic [IdxOutW+IW-1:0] t;
        t = {{IdxOutW{1'b0}}, b};
        return t[IdxOutW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        logic [IW-1:0] h, p, nx, b;
        logic [FlagW-1:0] f;
        logic [CW-1:0] cnt;
        logic [IW-1:0] hd, tl;
        t_result rs;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hash  <= '0;
            r_flags <= '0;
            r_onfl  <= '1;
            r_head  <= '0;
            r_tail  <= IW'(NUM_BUFFERS - 1);
            r_cnt   <= CNT_FULL;
            r_done  <= 1'b0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                r_tag[i]  <= '0;
                r_next[i] <= IW'((i + 1) % NUM_BUFFERS);
                r_prev[i] <= IW'((i + NUM_BUFFERS - 1) % NUM_BUFFERS);
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (req.valid) r_req <= req.payload;
                end
                S_LOOK: ;
                S_WORK: begin
                    rs = '0;
                    rs.last = 1'b1;
                    h = w_hidx;
                    f = r_flags[h];
                    cnt = r_cnt; hd = r_head; tl = r_tail;
                    if (r_req.action == ACT_GET && !w_hit) begin
                        b = r_head;
                        if (r_cnt == '0) begin
                            rs.status = ST_EMPTY;
                        end else begin
                            p = r_prev[b]; nx = r_next[b];
                            if (r_head == b) r_head <= nx; else r_next[p] <= nx;
                            if (r_tail == b) r_tail <= p; else r_prev[nx] <= p;
                            r_onfl[b] <= 1'b0;
                            r_cnt <= r_cnt - 1'b1;
                            rs.buffer_index = ext_idx(b);
                            rs.other_block = r_hash[b] ? ext_blk(r_tag[b]) : '0;
                            rs.other_block_present = r_hash[b];
                            if (r_flags[b][F_DWR]) begin
                                r_flags[b][F_LOCKED] <= 1'b1;
                                rs.status = ST_WRITEBACK;
                                rs.last = 1'b0;
                            end else begin
                                r_flags[b][F_LOCKED] <= 1'b1;
                                r_flags[b][F_VALID]  <= 1'b0;
                                r_tag[b]  <= w_blk;
                                r_hash[b] <= 1'b1;
                                rs.status = ST_REPLACED;
                            end
                        end
                    end else if (r_req.action == ACT_GET) begin
                        rs.buffer_index = ext_idx(h);
                        if (f[F_LOCKED]) begin
                            r_flags[h][F_WAITED] <= 1'b1;
                            rs.status = ST_LOCKWAIT;
                        end else begin
                            r_flags[h][F_LOCKED] <= 1'b1;
                            rs.status = ST_HIT;
                            if (r_onfl[h]) begin
                                p = r_prev[h]; nx = r_next[h];
                                if (r_head == h) r_head <= nx; else r_next[p] <= nx;
                                if (r_tail == h) r_tail <= p; else r_prev[nx] <= p;
                                r_onfl[h] <= 1'b0;
                                r_cnt <= r_cnt - 1'b1;
                            end
                        end
                    end else if (r_req.action == ACT_REL) begin
                        if (!w_hit) begin
                            rs.status = ST_NOTCACHED;
                        end else if (!f[F_LOCKED]) begin
                            rs.status = ST_NOTLOCKED;
                            rs.buffer_index = ext_idx(h);
                        end else begin
                            rs.buffer_index = ext_idx(h);
                            rs.wake_any = (r_cnt == '0);
                            rs.wake_block_waiters = f[F_WAITED];
                            if (!f[F_VALID]) begin
                                rs.status = ST_INVALID;
                            end else begin
                                rs.status = ST_RELEASED;
                                // Unlink then relink; head, tail and count are tracked on local copies.
                                if (r_onfl[h]) begin
                                    p = r_prev[h]; nx = r_next[h];
                                    if (hd == h) hd = nx; else r_next[p] <= nx;
                                    if (tl == h) tl = p; else r_prev[nx] <= p;
                                    cnt = cnt - 1'b1;
                                end
                                if (f[F_OLD]) begin
                                    if (cnt == '0) tl = h;
                                    else begin
                                        r_prev[hd] <= h;
                                        r_next[h] <= hd;
                                    end
                                    hd = h;
                                    r_flags[h][F_OLD] <= 1'b0;
                                end else begin
                                    if (cnt == '0) hd = h;
                                    else begin
                                        r_next[tl] <= h;
                                        r_prev[h] <= tl;
                                    end
                                    tl = h;
                                end
                                r_flags[h][F_LOCKED] <= 1'b0;
                                r_onfl[h] <= 1'b1;
                                r_head <= hd; r_tail <= tl;
                                r_cnt <= cnt + 1'b1;
                            end
                        end
                    end else begin
                        if (w_hit) rs.buffer_index = ext_idx(h);
                        if (!w_hit || r_req.flag_select > SEL_MAX) begin
                            rs.status = ST_FLAGMISS;
                        end else begin
                            rs.status = ST_FLAGDONE;
                            r_flags[h][r_req.flag_select] <=
                                (r_req.action == ACT_SET);
                        end
                    end
                    r_res <= rs;
                    r_done <= rs.last;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (req.valid) n_state = S_LOOK;
            S_LOOK: n_state = S_WORK;
            S_WORK: n_state = S_OUT;
            S_OUT: begin
                if (res.ready) n_state = r_done ? S_IDLE : S_WORK;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/core/bcgb_checker.sv
// Port-level checker for the buffer cache controller, bound to the top level.
// Depends on bcgb_pkg.
`default_nettype none
module bcgb_checker import bcgb_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     req_valid,
    input wire logic     req_ready,
    input wire logic     res_valid,
    input wire logic     res_ready,
    input wire t_result  res_payload
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !req_ready) else $error("request taken during result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_payload))
        else $error("result changed while stalled");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready) else $error("ready after accept");
    a_nonlast_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_payload.last |-> res_payload.status == ST_WRITEBACK)
        else $error("non-final result is not a writeback");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res_payload.status <= ST_FLAGMISS) else $error("bad status");
endmodule

bind buffer_cache_getblk_brelse bcgb_checker u_bcgb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .res_valid(res.valid), .res_ready(res.ready), .res_payload(res.payload)
);
`default_nettype wire
